// ----- sv/cpbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Command packet parser package
// Shared types, character codes and the motion letter decode.
// ----------------------------------------------------------------------------
package cpbp_pkg;

    localparam int PACKET_BYTES = 16;
    localparam int CNT_W        = $clog2(PACKET_BYTES);

    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic [6:0] SPEED_MAX     = 7'd100;
    localparam logic [6:0] SPEED_DEFAULT = 7'd80;

    typedef enum logic [2:0] {
        MOT_FWD  = 3'd0,
        MOT_REV  = 3'd1,
        MOT_LEFT = 3'd2,
        MOT_RGHT = 3'd3,
        MOT_STOP = 3'd4
    } motion_t;

    typedef enum logic [2:0] {
        PH_MOTION = 3'd0,
        PH_COMMA1 = 3'd1,
        PH_DIGITS = 3'd2,
        PH_MODE   = 3'd3,
        PH_IGNORE = 3'd4
    } phase_t;

    typedef struct packed {
        logic    hit;
        motion_t code;
    } letter_t;

    typedef struct packed {
        logic       hit;
        motion_t    motion;
        logic [6:0] speed;
        logic       auto_avoid;
    } result_t;

    function automatic letter_t letter_code(input logic [7:0] b);
        letter_t l;
        l.hit  = 1'b1;
        l.code = MOT_STOP;
        case (b)
            "U", "u", "F", "f":                l.code = MOT_FWD;
            "D", "d", "B", "b":                l.code = MOT_REV;
            "L", "l":                          l.code = MOT_LEFT;
            "R", "r", "X", "x":                l.code = MOT_RGHT;
            "S", "s", "0", "C", "c", "N", "n": l.code = MOT_STOP;
            default:                           l.hit  = 1'b0;
        endcase
        return l;
    endfunction

endpackage

// ----- sv/cpbp_parser.sv -----
// ----------------------------------------------------------------------------
// Command packet parser core
// Holds the packet state and decodes one byte per step into at most one
// drive command.
// ----------------------------------------------------------------------------
module cpbp_parser
    import cpbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic [6:0] default_speed,
    output result_t    result
);

    logic             in_packet_reg, in_packet_next;
    logic [CNT_W-1:0] count_reg, count_next;
    phase_t           phase_reg, phase_next;
    motion_t          motion_reg, motion_next;
    logic             bad_reg, bad_next;
    logic [6:0]       speed_reg, speed_next;
    logic             given_reg, given_next;
    logic             mode_reg, mode_next;

    letter_t    letter;
    logic [6:0] dflt;
    logic [9:0] acc;
    logic       is_digit;

    logic       hit;
    motion_t    res_motion;
    logic [6:0] res_speed;
    logic       res_mode;

    assign letter   = letter_code(byte_in);
    assign dflt     = (default_speed > SPEED_MAX) ? SPEED_MAX : default_speed;
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign acc      = 10'(speed_reg) * 10'd10 + 10'(byte_in[3:0]);

    // next state
    always_comb
    begin
        in_packet_next = in_packet_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        motion_next    = motion_reg;
        bad_next       = bad_reg;
        speed_next     = speed_reg;
        given_next     = given_reg;
        mode_next      = mode_reg;
        hit            = 1'b0;
        res_motion     = letter.code;
        res_speed      = dflt;
        res_mode       = 1'b0;

        priority if (byte_in == CH_OPEN)
        begin
            in_packet_next = 1'b1;
            count_next     = '0;
            phase_next     = PH_MOTION;
            motion_next    = MOT_STOP;
            bad_next       = 1'b0;
            speed_next     = '0;
            given_next     = 1'b0;
            mode_next      = 1'b0;
        end
        else if (!in_packet_reg)
        begin
            hit = letter.hit;
        end
        else if (byte_in == CH_CLOSE)
        begin
            in_packet_next = 1'b0;
            hit            = (count_reg != '0) && !bad_reg;
            res_motion     = motion_reg;
            res_speed      = given_reg ? speed_reg : dflt;
            res_mode       = mode_reg;
        end
        else if (count_reg >= CNT_W'(PACKET_BYTES - 1))
        begin
            // overflow: drop the packet and retry the byte as a letter
            in_packet_next = 1'b0;
            count_next     = '0;
            hit            = letter.hit;
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
            unique case (phase_reg)
                PH_MOTION:
                begin
                    bad_next    = !letter.hit;
                    motion_next = letter.code;
                    phase_next  = PH_COMMA1;
                end
                PH_COMMA1:
                begin
                    if (byte_in == CH_COMMA)
                    begin
                        given_next = 1'b1;
                        speed_next = '0;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_DIGITS:
                begin
                    priority if (is_digit)
                        speed_next = (acc > 10'(SPEED_MAX)) ? SPEED_MAX : acc[6:0];
                    else if (byte_in == CH_COMMA)
                        phase_next = PH_MODE;
                    else
                        phase_next = PH_IGNORE;
                end
                PH_MODE:
                begin
                    mode_next  = (byte_in == CH_ONE);
                    phase_next = PH_IGNORE;
                end
                default:
                begin
                    phase_next = PH_IGNORE;
                end
            endcase
        end
    end

    // result; stop always carries speed 0
    always_comb
    begin
        result.hit        = hit;
        result.motion     = res_motion;
        result.speed      = (res_motion == MOT_STOP) ? 7'd0 : res_speed;
        result.auto_avoid = res_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= PH_MOTION;
            motion_reg    <= MOT_STOP;
            bad_reg       <= 1'b0;
            speed_reg     <= '0;
            given_reg     <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else if (step)
        begin
            in_packet_reg <= in_packet_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            motion_reg    <= motion_next;
            bad_reg       <= bad_next;
            speed_reg     <= speed_next;
            given_reg     <= given_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

// ----- sv/command_packet_byte_parser.sv -----
// ----------------------------------------------------------------------------
// Command packet byte parser
// Turns received serial bytes into drive commands (motion, speed, mode).
// ----------------------------------------------------------------------------
// Path: the transfer of the byte that completes a command loads the input
//   register; the parser step that takes it, once the result slot is free or
//   being drained, loads the result register, which offers the command.
// Throughput: one byte per cycle unless a full, undrained result slot stalls it.
// Reset: rst_n clears the packet state and both registers at once;
//   default_speed returns to 80.
module command_packet_byte_parser
    import cpbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] motion,
    output logic [6:0] speed_percent,
    output logic       auto_avoid
);

    logic [6:0] dspeed_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    motion_t    motion_reg;
    logic [6:0] speed_reg;
    logic       auto_reg;
    logic       step;
    result_t    result;

    // advance when the result slot is free or being drained this cycle
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    cpbp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .byte_in       (in_byte_reg),
        .default_speed (dspeed_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dspeed_reg <= SPEED_DEFAULT;
        else if (cfg_write)
            dspeed_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
            in_byte_reg  <= rx_byte;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            motion_reg    <= MOT_STOP;
            speed_reg     <= '0;
            auto_reg      <= 1'b0;
        end
        else if (step && result.hit)
        begin
            out_valid_reg <= 1'b1;
            motion_reg    <= result.motion;
            speed_reg     <= result.speed;
            auto_reg      <= result.auto_avoid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motion        = motion_reg;
    assign speed_percent = speed_reg;
    assign auto_avoid    = auto_reg;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command packet byte parser testbench
// Drives serial bytes through the valid/ready input. Each byte transfer is run
// through a behavioural parser that builds the expected drive commands. Every
// output transfer is checked field by field against the oldest pending one.
// A short directed table comes first. Random single letters, packets,
// overflowing and broken packets and noise bytes follow, under three pacing
// schemes and several default speed settings.
// ----------------------------------------------------------------------------
module tb;
    import cpbp_pkg::*;

    localparam int RAND_BYTES     = 260;
    localparam int HOLD_CYCLES    = 80;
    localparam int PRESSURE_BYTES = 40;
    localparam int TAIL_CYCLES    = 4;
    localparam int QUIET_LIMIT    = 2000;

    localparam result_t NO_CMD = '{hit: 1'b0, motion: MOT_STOP, speed: 7'd0,
                                   auto_avoid: 1'b0};

    typedef struct {
        logic [7:0] b;
        bit         known;   // expectation typed in below rather than predicted
        result_t    want;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic [6:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] motion;
    logic [6:0] speed_percent;
    logic       auto_avoid;

    // parser state mirrored from the byte stream
    logic       pk_open;
    logic [3:0] pk_count;
    phase_t     pk_phase;
    motion_t    pk_motion;
    logic       pk_bad;
    logic [6:0] pk_speed;
    logic       pk_speed_given;
    logic       pk_auto;
    logic [6:0] dflt_reg;

    result_t    cmd_expect[$];
    dir_row_t   pending_rows[$];
    logic [7:0] burst[$];

    int tx_idle_pct = 9;
    int rx_idle_pct = 74;
    bit stall_req   = 1'b0;
    int quiet_cycles = 0;
    int n_bytes    = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 0;

    string MOTION_LETTERS = "UuFfDdBbLlRrXxSs0CcNn";

    dir_row_t dir_rows [0:24] = '{
        '{"F",      1'b1, '{1'b1, MOT_FWD, 7'd80, 1'b0}},
        '{"n",      1'b1, '{1'b1, MOT_STOP, 7'd0, 1'b0}},
        '{CH_CLOSE, 1'b1, NO_CMD},
        '{8'hFF,    1'b1, NO_CMD},
        '{8'h00,    1'b1, NO_CMD},
        '{CH_OPEN,  1'b1, NO_CMD},
        '{CH_CLOSE, 1'b1, NO_CMD},
        '{CH_OPEN,  1'b1, NO_CMD},
        '{CH_OPEN,  1'b1, NO_CMD},
        '{"R",      1'b0, NO_CMD},
        '{CH_COMMA, 1'b0, NO_CMD},
        '{"9",      1'b0, NO_CMD},
        '{"9",      1'b0, NO_CMD},
        '{"9",      1'b0, NO_CMD},
        '{CH_COMMA, 1'b0, NO_CMD},
        '{CH_ONE,   1'b0, NO_CMD},
        '{"z",      1'b0, NO_CMD},
        '{CH_CLOSE, 1'b1, '{1'b1, MOT_RGHT, 7'd100, 1'b1}},
        '{CH_OPEN,  1'b1, NO_CMD},
        '{"q",      1'b0, NO_CMD},
        '{CH_CLOSE, 1'b1, NO_CMD},
        '{CH_OPEN,  1'b0, NO_CMD},
        '{"b",      1'b0, NO_CMD},
        '{CH_COMMA, 1'b0, NO_CMD},
        '{CH_CLOSE, 1'b0, NO_CMD}
    };

    command_packet_byte_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .motion        (motion),
        .speed_percent (speed_percent),
        .auto_avoid    (auto_avoid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_packet();
        pk_count       = '0;
        pk_phase       = PH_MOTION;
        pk_motion      = MOT_STOP;
        pk_bad         = 1'b0;
        pk_speed       = '0;
        pk_speed_given = 1'b0;
        pk_auto        = 1'b0;
    endfunction

    function automatic logic [6:0] dflt_speed();
        return (dflt_reg > SPEED_MAX) ? SPEED_MAX : dflt_reg;
    endfunction

    function automatic result_t make_cmd(input motion_t m, input logic [6:0] s,
                                         input logic aa);
        result_t r;
        r.hit        = 1'b1;
        r.motion     = m;
        r.speed      = (m == MOT_STOP) ? 7'd0 : s;
        r.auto_avoid = aa;
        return r;
    endfunction

    // Advance the parser by one byte; return the command it completes, if any.
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        motion_t m;
        logic    hit;
        int      v;
        r   = NO_CMD;
        hit = 1'b1;
        if (b inside {"U", "u", "F", "f"})
            m = MOT_FWD;
        else if (b inside {"D", "d", "B", "b"})
            m = MOT_REV;
        else if (b inside {"L", "l"})
            m = MOT_LEFT;
        else if (b inside {"R", "r", "X", "x"})
            m = MOT_RGHT;
        else if (b inside {"S", "s", "0", "C", "c", "N", "n"})
            m = MOT_STOP;
        else
        begin
            hit = 1'b0;
            m   = MOT_STOP;
        end

        if (b == CH_OPEN)
        begin
            pk_open = 1'b1;
            clear_packet();
        end
        else if (!pk_open)
        begin
            if (hit)
                r = make_cmd(m, dflt_speed(), 1'b0);
        end
        else if (b == CH_CLOSE)
        begin
            pk_open = 1'b0;
            if (pk_count != 0 && !pk_bad)
                r = make_cmd(pk_motion, pk_speed_given ? pk_speed : dflt_speed(), pk_auto);
        end
        else if (pk_count >= PACKET_BYTES - 1)
        begin
            // drop the overlong packet and try the byte on its own
            pk_open  = 1'b0;
            pk_count = '0;
            if (hit)
                r = make_cmd(m, dflt_speed(), 1'b0);
        end
        else
        begin
            case (pk_phase)
                PH_MOTION:
                begin
                    pk_bad    = !hit;
                    pk_motion = m;
                    pk_phase  = PH_COMMA1;
                end
                PH_COMMA1:
                begin
                    if (b == CH_COMMA)
                    begin
                        pk_speed_given = 1'b1;
                        pk_speed       = '0;
                        pk_phase       = PH_DIGITS;
                    end
                    else
                        pk_phase = PH_IGNORE;
                end
                PH_DIGITS:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        v        = int'(pk_speed) * 10 + int'(b - CH_ZERO);
                        pk_speed = (v > int'(SPEED_MAX)) ? SPEED_MAX : 7'(v);
                    end
                    else if (b == CH_COMMA)
                        pk_phase = PH_MODE;
                    else
                        pk_phase = PH_IGNORE;
                end
                PH_MODE:
                begin
                    pk_auto  = (b == CH_ONE);
                    pk_phase = PH_IGNORE;
                end
                default:
                    pk_phase = PH_IGNORE;
            endcase
            pk_count = pk_count + 4'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_letter();
        return MOTION_LETTERS[$urandom_range(0, MOTION_LETTERS.len() - 1)];
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    function automatic logic [7:0] digit_byte();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Fill burst with one random sequence: a packet, an overlong packet, a letter, a noise byte or an open packet.
    function automatic void build_burst();
        int kind;
        burst.delete();
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            burst.push_back(CH_OPEN);
            burst.push_back(($urandom_range(0, 9) != 0) ? pick_letter() : body_byte());
            if ($urandom_range(0, 3) != 0)
            begin
                burst.push_back(CH_COMMA);
                repeat ($urandom_range(0, 4)) burst.push_back(digit_byte());
                if ($urandom_range(0, 2) != 0)
                begin
                    burst.push_back(CH_COMMA);
                    burst.push_back(($urandom_range(0, 2) != 0) ? CH_ONE : body_byte());
                end
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) burst.push_back(body_byte());
            burst.push_back(CH_CLOSE);
        end
        else if (kind < 60)
        begin
            // run the packet up to, and at times past, its length limit
            burst.push_back(CH_OPEN);
            burst.push_back(pick_letter());
            burst.push_back(CH_COMMA);
            repeat ($urandom_range(11, 14))
                burst.push_back(($urandom_range(0, 3) != 0) ? digit_byte() : body_byte());
            burst.push_back(($urandom_range(0, 1) != 0) ? CH_CLOSE : pick_letter());
        end
        else if (kind < 80)
            burst.push_back(pick_letter());
        else if (kind < 90)
            burst.push_back(8'($urandom_range(0, 255)));
        else
        begin
            // packet left open: later bytes land inside it
            burst.push_back(CH_OPEN);
            burst.push_back(pick_letter());
            burst.push_back(CH_COMMA);
            repeat ($urandom_range(0, 3)) burst.push_back(digit_byte());
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Hold the sender until every pending command has come out.
    task automatic settle();
        while (cmd_expect.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_speed(input logic [6:0] v);
        cfg_data  <= v;
        cfg_write <= 1'b1;
        dflt_reg   = v;
        @(negedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    always @(posedge clk)
    begin : track_input
        result_t  c;
        dir_row_t row;
        if (rst_n && in_valid && in_ready)
        begin
            c = parse_byte(rx_byte);
            if (pending_rows.size() != 0)
            begin
                row = pending_rows.pop_front();
                if (row.known)
                    c = row.want;
            end
            if (c.hit)
                cmd_expect.push_back(c);
            n_bytes++;
        end
    end

    always @(posedge clk)
    begin : check_output
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cmd_expect.size() == 0)
            begin
                $display("%0t: unexpected command motion=%0d speed=%0d auto=%0d",
                         $time, motion, speed_percent, auto_avoid);
                n_errors++;
            end
            else
            begin
                want = cmd_expect.pop_front();
                n_checked++;
                if (motion !== want.motion)
                begin
                    $display("%0t: motion expected %0d actual %0d",
                             $time, want.motion, motion);
                    n_errors++;
                end
                if (speed_percent !== want.speed)
                begin
                    $display("%0t: speed_percent expected %0d actual %0d",
                             $time, want.speed, speed_percent);
                    n_errors++;
                end
                if (auto_avoid !== want.auto_avoid)
                begin
                    $display("%0t: auto_avoid expected %0d actual %0d",
                             $time, want.auto_avoid, auto_avoid);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : drive_output_ready
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_req = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        int sent;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        pk_open   = 1'b0;
        clear_packet();
        dflt_reg  = SPEED_DEFAULT;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            pending_rows.push_back(dir_rows[i]);
            send_byte(dir_rows[i].b);
        end
        in_valid <= 1'b0;
        settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 74;
                    write_speed(SPEED_MAX);
                end
                1:
                begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 9;
                    write_speed(7'd0);
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    write_speed(7'd91);
                    // long receiver hold-off while letters keep coming in
                    stall_req = 1'b1;
                    repeat (PRESSURE_BYTES) send_byte(pick_letter());
                    in_valid <= 1'b0;
                    settle();
                    // settings above 100 clamp to 100
                    write_speed(7'($urandom_range(1, 127)));
                end
            endcase
            sent = 0;
            while (sent < RAND_BYTES)
            begin
                build_burst();
                foreach (burst[i])
                    send_byte(burst[i]);
                sent += burst.size();
            end
            in_valid <= 1'b0;
            settle();
        end

        if (cmd_expect.size() != 0)
        begin
            $display("%0t: %0d commands never arrived", $time, cmd_expect.size());
            n_errors++;
        end
        $display("Run took %0d byte transfers and checked %0d commands over %0d speed settings.",
                 n_bytes, n_checked, n_settings);
        $display("Pacing: slow receiver, slow sender, unthrottled with a long output hold-off.");
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
